// File: rtl/aps_pkg.sv
// Shared types and constants for the archive path sanitizer.
// Used by aps_step, archive_path_sanitizer_unit and the port checker.
package aps_pkg;

  // Hard ceiling on the path byte counter
  localparam int unsigned MaxPathBytes = 4096;
  localparam int unsigned CountW       = $clog2(MaxPathBytes + 1);
  localparam int unsigned NameLimitW   = 8;
  localparam int unsigned PathLimitW   = 13;
  localparam int unsigned CfgDataW     = 13;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CompLenW     = 9;
  localparam int unsigned CompLenMax   = 256;

  // Register indexes on the write port
  localparam logic [CfgIdxW-1:0] RegNameLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPathLimit = 2'd1;

  localparam logic [NameLimitW-1:0] NameLimitReset = 8'd255;
  localparam logic [PathLimitW-1:0] PathLimitReset = 13'd1024;

  // Characters of interest
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChDot       = 8'h2E;
  localparam logic [7:0] ChColon     = 8'h3A;
  localparam logic [7:0] ChNul       = 8'h00;

  // UTF-8 lead byte ranges and code point bounds
  localparam logic [7:0]  Lead2Lo     = 8'hC2;
  localparam logic [7:0]  Lead2Hi     = 8'hDF;
  localparam logic [7:0]  Lead3Lo     = 8'hE0;
  localparam logic [7:0]  Lead3Hi     = 8'hEF;
  localparam logic [7:0]  Lead4Lo     = 8'hF0;
  localparam logic [7:0]  Lead4Hi     = 8'hF4;
  localparam logic [20:0] Min3Byte    = 21'h000800;
  localparam logic [20:0] Min4Byte    = 21'h010000;
  localparam logic [20:0] MaxCodept   = 21'h10FFFF;
  localparam logic [20:0] SurrogateLo = 21'h00D800;
  localparam logic [20:0] SurrogateHi = 21'h00DFFF;

  // Count of continuation bytes following a lead byte
  localparam logic [1:0] SeqCont1 = 2'd1;
  localparam logic [1:0] SeqCont2 = 2'd2;
  localparam logic [1:0] SeqCont3 = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_present;
    logic       finished;
    logic       verdict;
  } out_word_t;

  // Running state of the path being checked
  typedef struct packed {
    logic [CountW-1:0]   byte_count;
    logic [CompLenW-1:0] comp_len;
    logic                all_dots;
    logic                in_first_component;
    logic                rejected;
    logic [1:0]          utf8_remaining;
    logic [1:0]          utf8_sequence_length;
    logic [20:0]         utf8_codepoint;
  } path_state_t;

  localparam path_state_t PathStateReset = '{
    byte_count:           '0,
    comp_len:             '0,
    all_dots:             1'b1,
    in_first_component:   1'b1,
    rejected:             1'b0,
    utf8_remaining:       2'd0,
    utf8_sequence_length: 2'd0,
    utf8_codepoint:       21'd0
  };

endpackage

// File: rtl/aps_step.sv
// Per-byte check and normalize logic of the archive path sanitizer.
// Pure combinational step: current path state and one word in, next state
// and one result word out. Depends on aps_pkg.
module aps_step (
  input  aps_pkg::path_state_t             state_i,
  input  logic [aps_pkg::NameLimitW-1:0]   name_limit_i,
  input  logic [aps_pkg::PathLimitW-1:0]   path_limit_i,
  input  aps_pkg::in_word_t                word_i,
  output aps_pkg::path_state_t             state_o,
  output aps_pkg::out_word_t               result_o
);

  localparam logic [aps_pkg::CountW-1:0] CountMax = aps_pkg::CountW'(aps_pkg::MaxPathBytes);
  localparam logic [aps_pkg::CompLenW-1:0] CompMax =
    aps_pkg::CompLenW'(aps_pkg::CompLenMax);

  always_comb begin
    aps_pkg::path_state_t        nxt;
    logic [7:0]                  b;
    logic                        last;
    logic                        rej;
    logic                        present;
    logic [7:0]                  ob;
    logic [aps_pkg::CountW-1:0]  limit;
    logic [20:0]                 cp;
    logic                        is_sep;

    nxt     = state_i;
    b       = word_i.in_byte;
    last    = word_i.is_last;
    rej     = state_i.rejected;
    present = 1'b0;
    ob      = aps_pkg::ChNul;
    limit   = (aps_pkg::CountW'(path_limit_i) < CountMax) ?
              aps_pkg::CountW'(path_limit_i) : CountMax;
    cp      = '0;
    is_sep  = (b == aps_pkg::ChSlash) || (b == aps_pkg::ChBackslash);

    if (!state_i.rejected) begin
      // Length of the whole path, saturating
      if (state_i.byte_count < CountMax) begin
        nxt.byte_count = state_i.byte_count + 1'b1;
      end
      if (nxt.byte_count >= limit) rej = 1'b1;
      if (b == aps_pkg::ChNul) rej = 1'b1;

      // UTF-8 decode: continuation byte or lead byte
      if (state_i.utf8_remaining != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          rej = 1'b1;
        end else begin
          cp = {state_i.utf8_codepoint[14:0], b[5:0]};
          nxt.utf8_codepoint = cp;
          nxt.utf8_remaining = state_i.utf8_remaining - 2'd1;
          if (nxt.utf8_remaining == 2'd0) begin
            if ((state_i.utf8_sequence_length == aps_pkg::SeqCont2 &&
                 cp < aps_pkg::Min3Byte) ||
                (state_i.utf8_sequence_length == aps_pkg::SeqCont3 &&
                 cp < aps_pkg::Min4Byte) ||
                cp > aps_pkg::MaxCodept ||
                (cp >= aps_pkg::SurrogateLo && cp <= aps_pkg::SurrogateHi)) begin
              rej = 1'b1;
            end
          end
        end
      end else if (b[7]) begin
        if (b >= aps_pkg::Lead2Lo && b <= aps_pkg::Lead2Hi) begin
          nxt.utf8_sequence_length = aps_pkg::SeqCont1;
          nxt.utf8_codepoint       = {16'd0, b[4:0]};
          nxt.utf8_remaining       = aps_pkg::SeqCont1;
        end else if (b >= aps_pkg::Lead3Lo && b <= aps_pkg::Lead3Hi) begin
          nxt.utf8_sequence_length = aps_pkg::SeqCont2;
          nxt.utf8_codepoint       = {17'd0, b[3:0]};
          nxt.utf8_remaining       = aps_pkg::SeqCont2;
        end else if (b >= aps_pkg::Lead4Lo && b <= aps_pkg::Lead4Hi) begin
          nxt.utf8_sequence_length = aps_pkg::SeqCont3;
          nxt.utf8_codepoint       = {18'd0, b[2:0]};
          nxt.utf8_remaining       = aps_pkg::SeqCont3;
        end else begin
          rej = 1'b1;
        end
      end
      // Open sequence at end of path
      if (last && nxt.utf8_remaining != 2'd0) rej = 1'b1;

      // Component rules
      if (is_sep) begin
        if (state_i.comp_len == '0) begin
          rej = 1'b1;
        end else if (state_i.comp_len <= aps_pkg::CompLenW'(2) &&
                     state_i.all_dots) begin
          rej = 1'b1;
        end else begin
          ob                     = aps_pkg::ChSlash;
          present                = !last;
          nxt.comp_len           = '0;
          nxt.all_dots           = 1'b1;
          nxt.in_first_component = 1'b0;
        end
      end else begin
        if (state_i.comp_len < CompMax) begin
          nxt.comp_len = state_i.comp_len + 1'b1;
        end
        if (nxt.comp_len > aps_pkg::CompLenW'(name_limit_i)) rej = 1'b1;
        if (b != aps_pkg::ChDot) nxt.all_dots = 1'b0;
        if (b == aps_pkg::ChColon && state_i.in_first_component) rej = 1'b1;
        ob      = b;
        present = 1'b1;
        if (last && nxt.comp_len <= aps_pkg::CompLenW'(2) && nxt.all_dots) begin
          rej = 1'b1;
        end
      end
      if (rej) present = 1'b0;
    end

    nxt.rejected = rej;
    // End of path: drop all path state
    if (last) nxt = aps_pkg::PathStateReset;

    state_o              = nxt;
    result_o.out_byte    = present ? ob : aps_pkg::ChNul;
    result_o.out_present = present;
    result_o.finished    = last;
    result_o.verdict     = last && rej;
  end

endmodule

// File: rtl/archive_path_sanitizer_unit.sv
// Archive path sanitizer top level: input register, per-byte step logic and
// result register, plus the two limit registers. Depends on aps_pkg, aps_step.
//
// One path byte is taken per word; every byte gives exactly one result word,
// moving from the input register to the result register, at a sustained rate
// of one byte per clock while the output is not stalled. The rate is set by
// the running path state (byte and component counters, UTF-8 decoder), which
// is updated as a byte moves from the input register to the result register.
// A byte is only accepted while the input register is free or draining, so
// input stall follows output stall combinationally. The verdict (0 accepted,
// 1 unsupported entry) appears on the result of the byte marked is_last,
// after which the path state starts afresh. Write the name and path limits
// only while no path is in flight.
module archive_path_sanitizer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [aps_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  aps_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output aps_pkg::out_word_t            out_word_o
);

  logic [aps_pkg::NameLimitW-1:0] name_limit_q;
  logic [aps_pkg::PathLimitW-1:0] path_limit_q;
  logic                           in_valid_q;
  aps_pkg::in_word_t              in_word_q;
  logic                           out_valid_q;
  aps_pkg::out_word_t             out_word_q;
  aps_pkg::path_state_t           state_q;
  aps_pkg::path_state_t           state_d;
  aps_pkg::out_word_t             result_d;
  logic                           advance;
  logic                           in_take;

  // Move a word to the result register when that register frees up
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  aps_step u_step (
    .state_i      (state_q),
    .name_limit_i (name_limit_q),
    .path_limit_i (path_limit_q),
    .word_i       (in_word_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  // Limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_limit_q <= aps_pkg::NameLimitReset;
      path_limit_q <= aps_pkg::PathLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aps_pkg::RegNameLimit: name_limit_q <= cfg_data_i[aps_pkg::NameLimitW-1:0];
        aps_pkg::RegPathLimit: path_limit_q <= cfg_data_i[aps_pkg::PathLimitW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_word_q <= in_word_i;
  end

  // Path state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aps_pkg::PathStateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_word_q <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// File: rtl/aps_port_checker.sv
// Port-level checks for archive_path_sanitizer_unit, bound to the top level.
// Depends on aps_pkg.
module aps_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input aps_pkg::out_word_t out_word_o
);

  // A rejection verdict only comes with the final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.verdict |-> out_word_o.finished)
    else $error("verdict set on a word that does not end the path");

  // A rejected final byte is never part of the emitted path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.verdict |-> !out_word_o.out_present)
    else $error("byte emitted on a rejected final word");

  // Absent bytes read as zero; emitted bytes are never NUL or backslash
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.out_present ?
      (out_word_o.out_byte != aps_pkg::ChNul &&
       out_word_o.out_byte != aps_pkg::ChBackslash) :
      (out_word_o.out_byte == aps_pkg::ChNul)))
    else $error("bad out_byte for out_present");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

endmodule

bind archive_path_sanitizer_unit aps_port_checker u_aps_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
